[hdl/rnc_pkg.sv]
package rnc_pkg;

   localparam logic [2:0] ST_HIT       = 3'd0;
   localparam logic [2:0] ST_INSERTED  = 3'd1;
   localparam logic [2:0] ST_REJECTED  = 3'd2;
   localparam logic [2:0] ST_HELD      = 3'd3;
   localparam logic [2:0] ST_FREED     = 3'd4;
   localparam logic [2:0] ST_UNCACHED  = 3'd5;
   localparam logic [2:0] ST_REL_ERROR = 3'd6;

   localparam logic MODE_RETRIEVE = 1'b0;
   localparam logic MODE_RELEASE  = 1'b1;

   typedef logic [2:0]  status_type;
   typedef logic [31:0] node_id_type;

endpackage

[hdl/rnc_key_cam.sv]
// associative key store: registered match, lowest-index hit and lowest free slot
module rnc_key_cam #(
   parameter int ENTRIES = 64,
   parameter int IDX_BITS = 6
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      search,
   input  rnc_pkg::node_id_type      search_key,
   input  logic                      wr_en,
   input  logic                      wr_valid,
   input  logic [IDX_BITS-1:0]       wr_idx,
   input  rnc_pkg::node_id_type      wr_key,
   input  logic [IDX_BITS-1:0]       rd_idx,
   output rnc_pkg::node_id_type      rd_key,
   output logic                      hit,
   output logic [IDX_BITS-1:0]       hit_idx,
   output logic                      slot_found,
   output logic [IDX_BITS-1:0]       slot_idx
);
   import rnc_pkg::*;

   logic [ENTRIES-1:0] valid_ff;
   node_id_type        key_ff [ENTRIES];
   logic [ENTRIES-1:0] match_ff;
   logic [ENTRIES-1:0] match_in;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match_in[i] = valid_ff[i] && (key_ff[i] == search_key);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= wr_valid;
      end
      if (wr_en && wr_valid) begin
         key_ff[wr_idx] <= wr_key;
      end
      if (search) begin
         match_ff <= match_in;
      end
      // key read is registered: it comes out in the cycle after the index
      rd_key <= key_ff[rd_idx];
   end

   // priority encoders over the registered match and valid vectors
   always_comb begin
      hit = 1'b0;
      hit_idx = '0;
      slot_found = 1'b0;
      slot_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit = 1'b1;
            hit_idx = IDX_BITS'(i);
         end
         if (!valid_ff[i]) begin
            slot_found = 1'b1;
            slot_idx = IDX_BITS'(i);
         end
      end
   end

endmodule

[hdl/rnc_entry_ram.sv]
// per-entry data memory: refs, dirty, free links; one write, one registered read
module rnc_entry_ram #(
   parameter int ENTRIES = 64,
   parameter int WIDTH = 8
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic [$clog2(ENTRIES)-1:0] rd_addr,
   output logic [WIDTH-1:0]           rd_data
);
   logic [WIDTH-1:0] mem [ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[hdl/refcounted_node_cache.sv]
// Reference-counted node cache. A transaction is taken when start is high and busy low; its
// single result appears on the rsp_ ports for one cycle with done high, and must be captured
// then since the block cannot be stalled. The next transaction can be taken in the cycle after
// done. The key search and the decision run through the search and read states; a hit, a held
// release or the first entry freed writes the entry memory that carries counts, dirty marks
// and the free-list links in the evaluate state, and an insert writes it in the insert state;
// leaving the free list adds one or two neighbor writes, an eviction adds those plus the
// insert, and freeing onto a nonempty list needs the head, the tail and the entry itself.
// Reset needs no clearing pass.
module refcounted_node_cache #(
   parameter int ENTRIES = 64,
   parameter int REF_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_mode,
   input  rnc_pkg::node_id_type req_node_id,
   input  logic                 req_dirty,
   output logic                 done,
   output rnc_pkg::status_type  rsp_status,
   output logic                 rsp_evicted_valid,
   output rnc_pkg::node_id_type rsp_evicted_id,
   output logic                 rsp_evicted_dirty,
   output logic [15:0]          rsp_ref_count
);
   import rnc_pkg::*;

   localparam int IB = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CB = $clog2(ENTRIES + 1);
   localparam int W  = REF_BITS + 1 + 2 * IB;
   localparam logic [REF_BITS-1:0] REF_MAX = '1;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_SEARCH  = 4'd1;
   localparam logic [3:0] S_READ    = 4'd2;
   localparam logic [3:0] S_EVAL    = 4'd3;
   localparam logic [3:0] S_UNLINK1 = 4'd4;
   localparam logic [3:0] S_UNLINK2 = 4'd5;
   localparam logic [3:0] S_INSERT  = 4'd6;
   localparam logic [3:0] S_PUSH1   = 4'd7;
   localparam logic [3:0] S_PUSH2   = 4'd8;
   localparam logic [3:0] S_WRITE   = 4'd9;
   localparam logic [3:0] S_DONE    = 4'd10;

   typedef struct packed {
      logic [REF_BITS-1:0] refs;
      logic                dirty;
      logic [IB-1:0]       nxt;
      logic [IB-1:0]       prv;
   } ent_type;

   logic [3:0]          state_ff, state_in;
   logic                mode_ff;
   node_id_type         key_ff;
   logic                dirty_ff;
   logic [IB-1:0]       e_ff, e_in;        // target entry
   ent_type             ent_ff, ent_in;    // target entry contents
   logic [IB-1:0]       aux_ff, aux_in;    // tail index while pushing
   logic                evict_ff, evict_in;
   logic [IB-1:0]       head_ff, head_in;
   logic                nonempty_ff, nonempty_in;
   logic [CB-1:0]       count_ff, count_in;
   status_type          status_ff, status_in;
   logic                ev_valid_ff, ev_valid_in;
   node_id_type         ev_id_ff, ev_id_in;
   logic                ev_dirty_ff, ev_dirty_in;
   logic [REF_BITS-1:0] refs_ff, refs_in;

   logic                ram_we;
   logic [IB-1:0]       ram_wa, ram_ra;
   ent_type             ram_wd, ram_rd;
   logic                cam_we, cam_wv, cam_hit, cam_slot_found;
   logic [IB-1:0]       cam_wi, cam_hit_idx, cam_slot_idx;
   node_id_type         cam_rd_key;

   rnc_key_cam #(.ENTRIES(ENTRIES), .IDX_BITS(IB)) u_cam (
      .clock(clock), .reset(reset),
      .search(state_ff == S_SEARCH), .search_key(key_ff),
      .wr_en(cam_we), .wr_valid(cam_wv), .wr_idx(cam_wi), .wr_key(key_ff),
      .rd_idx(e_in), .rd_key(cam_rd_key),
      .hit(cam_hit), .hit_idx(cam_hit_idx),
      .slot_found(cam_slot_found), .slot_idx(cam_slot_idx)
   );

   rnc_entry_ram #(.ENTRIES(ENTRIES), .WIDTH(W)) u_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(ram_ra), .rd_data(ram_rd)
   );

   always_comb begin
      state_in    = state_ff;
      e_in        = e_ff;
      ent_in      = ent_ff;
      aux_in      = aux_ff;
      evict_in    = evict_ff;
      head_in     = head_ff;
      nonempty_in = nonempty_ff;
      count_in    = count_ff;
      status_in   = status_ff;
      ev_valid_in = ev_valid_ff;
      ev_id_in    = ev_id_ff;
      ev_dirty_in = ev_dirty_ff;
      refs_in     = refs_ff;
      ram_we = 1'b0;
      ram_wa = e_ff;
      ram_wd = ent_ff;
      ram_ra = e_ff;
      cam_we = 1'b0;
      cam_wv = 1'b0;
      cam_wi = e_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            state_in = S_READ;
         end
         S_READ: begin
            // pick the target: hit entry, or free head for eviction
            evict_in = 1'b0;
            ev_valid_in = 1'b0;
            ev_id_in = '0;
            ev_dirty_in = 1'b0;
            refs_in = '0;
            if (cam_hit) begin
               e_in = cam_hit_idx;
               state_in = S_EVAL;
            end else if (mode_ff == MODE_RELEASE) begin
               status_in = ST_UNCACHED;
               state_in = S_DONE;
            end else if (count_ff < CB'(ENTRIES) && cam_slot_found) begin
               state_in = S_INSERT;
            end else if (nonempty_ff) begin
               e_in = head_ff;
               evict_in = 1'b1;
               state_in = S_EVAL;
            end else begin
               status_in = ST_REJECTED;
               state_in = S_DONE;
            end
            ram_ra = e_in;
         end
         S_EVAL: begin
            ent_in = ram_rd;
            if (evict_ff) begin
               ev_valid_in = 1'b1;
               ev_id_in = cam_rd_key;
               ev_dirty_in = ram_rd.dirty;
               cam_we = 1'b1;
               cam_wv = 1'b0;
               count_in = count_ff - 1'b1;
               if (ram_rd.nxt == e_ff) begin
                  nonempty_in = 1'b0;
                  head_in = '0;
                  state_in = S_INSERT;
               end else begin
                  head_in = ram_rd.nxt;
                  ram_ra = ram_rd.nxt;
                  state_in = S_UNLINK1;
               end
            end else if (mode_ff == MODE_RETRIEVE) begin
               if (ram_rd.refs < REF_MAX) begin
                  ent_in.refs = ram_rd.refs + 1'b1;
               end
               ram_we = 1'b1;
               ram_wd = ent_in;
               status_in = ST_HIT;
               refs_in = ent_in.refs;
               state_in = S_DONE;
               if (ram_rd.refs == '0) begin
                  // entry leaves the free list
                  if (ram_rd.nxt == e_ff) begin
                     nonempty_in = 1'b0;
                     head_in = '0;
                  end else begin
                     if (head_ff == e_ff) begin
                        head_in = ram_rd.nxt;
                     end
                     ram_ra = ram_rd.nxt;
                     state_in = S_UNLINK1;
                  end
               end
            end else if (ram_rd.refs == '0) begin
               status_in = ST_REL_ERROR;
               state_in = S_DONE;
            end else begin
               ent_in.refs = ram_rd.refs - 1'b1;
               ent_in.dirty = ram_rd.dirty | dirty_ff;
               refs_in = ent_in.refs;
               if (ent_in.refs != '0) begin
                  status_in = ST_HELD;
                  ram_we = 1'b1;
                  ram_wd = ent_in;
                  state_in = S_DONE;
               end else begin
                  status_in = ST_FREED;
                  if (nonempty_ff) begin
                     // need the head's back link (the tail)
                     ram_ra = head_ff;
                     state_in = S_PUSH1;
                  end else begin
                     ent_in.nxt = e_ff;
                     ent_in.prv = e_ff;
                     ram_we = 1'b1;
                     ram_wd = ent_in;
                     head_in = e_ff;
                     nonempty_in = 1'b1;
                     state_in = S_DONE;
                  end
               end
            end
         end
         S_UNLINK1: begin
            // ram_rd is the next entry: its back link skips the target
            ram_we = 1'b1;
            ram_wa = ent_ff.nxt;
            ram_wd = ram_rd;
            ram_wd.prv = ent_ff.prv;
            if (ent_ff.prv == ent_ff.nxt) begin
               ram_wd.nxt = ent_ff.nxt;
               state_in = evict_ff ? S_INSERT : S_DONE;
            end else begin
               ram_ra = ent_ff.prv;
               state_in = S_UNLINK2;
            end
         end
         S_UNLINK2: begin
            ram_we = 1'b1;
            ram_wa = ent_ff.prv;
            ram_wd = ram_rd;
            ram_wd.nxt = ent_ff.nxt;
            state_in = evict_ff ? S_INSERT : S_DONE;
         end
         S_INSERT: begin
            ram_we = 1'b1;
            ram_wa = cam_slot_idx;
            ram_wd.refs = REF_BITS'(1);
            ram_wd.dirty = dirty_ff;
            ram_wd.nxt = '0;
            ram_wd.prv = '0;
            cam_we = 1'b1;
            cam_wv = 1'b1;
            cam_wi = cam_slot_idx;
            count_in = count_ff + 1'b1;
            status_in = ST_INSERTED;
            refs_in = REF_BITS'(1);
            state_in = S_DONE;
         end
         S_PUSH1: begin
            // ram_rd is head: tail = head.prv; set head.prv = e
            ram_we = 1'b1;
            ram_wa = head_ff;
            ram_wd = ram_rd;
            ram_wd.prv = e_ff;
            ent_in.nxt = head_ff;
            ent_in.prv = ram_rd.prv;
            if (ram_rd.prv == head_ff) begin
               ram_wd.nxt = e_ff;
               state_in = S_WRITE;
            end else begin
               ram_ra = ram_rd.prv;
               aux_in = ram_rd.prv;
               state_in = S_PUSH2;
            end
         end
         S_PUSH2: begin
            ram_we = 1'b1;
            ram_wa = aux_ff;
            ram_wd = ram_rd;
            ram_wd.nxt = e_ff;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            ram_we = 1'b1;
            ram_wa = e_ff;
            ram_wd = ent_ff;
            head_in = e_ff;
            nonempty_in = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         head_ff     <= '0;
         nonempty_ff <= 1'b0;
         count_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         nonempty_ff <= nonempty_in;
         count_ff    <= count_in;
      end
      if (state_ff == S_IDLE && start) begin
         mode_ff  <= req_mode;
         key_ff   <= req_node_id;
         dirty_ff <= req_dirty;
      end
      e_ff        <= e_in;
      ent_ff      <= ent_in;
      aux_ff      <= aux_in;
      evict_ff    <= evict_in;
      status_ff   <= status_in;
      ev_valid_ff <= ev_valid_in;
      ev_id_ff    <= ev_id_in;
      ev_dirty_ff <= ev_dirty_in;
      refs_ff     <= refs_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign done              = (state_ff == S_DONE);
   assign rsp_status        = status_ff;
   assign rsp_evicted_valid = ev_valid_ff;
   assign rsp_evicted_id    = ev_id_ff;
   assign rsp_evicted_dirty = ev_dirty_ff;
   assign rsp_ref_count     = 16'(refs_ff);

endmodule

[hdl/rnc_checker.sv]
module rnc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 done,
   input rnc_pkg::status_type  rsp_status,
   input logic                 rsp_evicted_valid,
   input logic [15:0]          rsp_ref_count
);
   import rnc_pkg::*;

   // a result only follows an active transaction
   assert property (@(posedge clock) disable iff (reset) done |-> busy)
      else $error("done without busy");
   assert property (@(posedge clock) disable iff (reset) done |=> !busy)
      else $error("still busy after done");
   assert property (@(posedge clock) disable iff (reset)
      done && rsp_evicted_valid |-> rsp_status == ST_INSERTED)
      else $error("eviction without insert");
   assert property (@(posedge clock) disable iff (reset)
      done && (rsp_status == ST_REJECTED || rsp_status == ST_UNCACHED
               || rsp_status == ST_REL_ERROR) |-> rsp_ref_count == 16'd0)
      else $error("count on failed transaction");
   assert property (@(posedge clock) disable iff (reset) start && !busy |=> busy)
      else $error("transaction not taken");

endmodule

bind refcounted_node_cache rnc_checker u_rnc_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .done(done),
   .rsp_status(rsp_status), .rsp_evicted_valid(rsp_evicted_valid),
   .rsp_ref_count(rsp_ref_count)
);

[test/tb_refcounted_node_cache.sv]
module tb_refcounted_node_cache;
   timeunit 1ns;
   timeprecision 1ps;
   import rnc_pkg::*;

   localparam int NUM_ENTRIES = 64;
   localparam int REF_LIMIT = 65535;
   localparam int MAX_GAP = 12;
   localparam longint CYCLE_LIMIT = 4000000;

   typedef struct {
      logic        mode;
      node_id_type node_id;
      logic        dirty;
      int          gap;
      bit          drain;
   } cache_req_type;

   typedef struct {
      status_type  status;
      logic        ev_valid;
      node_id_type ev_id;
      logic        ev_dirty;
      logic [15:0] refs;
   } cache_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_mode = 1'b0;
   node_id_type req_node_id = '0;
   logic req_dirty = 1'b0;
   logic done;
   status_type rsp_status;
   logic rsp_evicted_valid;
   node_id_type rsp_evicted_id;
   logic rsp_evicted_dirty;
   logic [15:0] rsp_ref_count;

   refcounted_node_cache u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_node_id(req_node_id), .req_dirty(req_dirty),
      .done(done), .rsp_status(rsp_status), .rsp_evicted_valid(rsp_evicted_valid),
      .rsp_evicted_id(rsp_evicted_id), .rsp_evicted_dirty(rsp_evicted_dirty),
      .rsp_ref_count(rsp_ref_count)
   );

   always #6 clock = ~clock;

   // shadow copy of the cache table
   bit          sh_valid [NUM_ENTRIES];
   node_id_type sh_key [NUM_ENTRIES];
   int          sh_refs [NUM_ENTRIES];
   bit          sh_dirty [NUM_ENTRIES];
   int          sh_next [NUM_ENTRIES];
   int          sh_prev [NUM_ENTRIES];
   int          sh_head = 0;
   bit          sh_nonempty = 0;
   int          sh_stored = 0;

   cache_req_type pending_reqs[$];
   cache_rsp_type expected_rsps[$];
   int mismatches = 0;
   int wait_cnt = 0;
   longint cycles = 0;

   function automatic void free_unlink(int e);
      int nx, pv;
      nx = sh_next[e];
      pv = sh_prev[e];
      if (nx == e) begin
         sh_nonempty = 0;
         sh_head = 0;
         return;
      end
      sh_next[pv] = nx;
      sh_prev[nx] = pv;
      if (sh_head == e) sh_head = nx;
   endfunction

   function automatic void free_push(int e);
      int tail;
      if (!sh_nonempty) begin
         sh_next[e] = e;
         sh_prev[e] = e;
      end else begin
         tail = sh_prev[sh_head];
         sh_next[e] = sh_head;
         sh_prev[e] = tail;
         sh_prev[sh_head] = e;
         sh_next[tail] = e;
      end
      sh_head = e;
      sh_nonempty = 1;
   endfunction

   function automatic cache_rsp_type cache_predict(cache_req_type r);
      cache_rsp_type p;
      int idx, slot, v;
      bit room;
      p = '{ST_HIT, 1'b0, '0, 1'b0, '0};
      idx = -1;
      for (int i = 0; i < NUM_ENTRIES; i++)
         if (idx < 0 && sh_valid[i] && sh_key[i] == r.node_id) idx = i;
      if (r.mode == MODE_RETRIEVE) begin
         if (idx >= 0) begin
            if (sh_refs[idx] == 0) free_unlink(idx);
            if (sh_refs[idx] < REF_LIMIT) sh_refs[idx]++;
            p.refs = 16'(sh_refs[idx]);
         end else begin
            room = sh_stored < NUM_ENTRIES;
            if (!room && sh_nonempty) begin
               v = sh_head;
               free_unlink(v);
               p.ev_valid = 1'b1;
               p.ev_id = sh_key[v];
               p.ev_dirty = sh_dirty[v];
               sh_valid[v] = 0;
               sh_stored--;
               room = 1;
            end
            p.status = ST_REJECTED;
            if (room) begin
               slot = -1;
               for (int i = 0; i < NUM_ENTRIES; i++)
                  if (slot < 0 && !sh_valid[i]) slot = i;
               sh_valid[slot] = 1;
               sh_key[slot] = r.node_id;
               sh_refs[slot] = 1;
               sh_dirty[slot] = r.dirty;
               sh_stored++;
               p.status = ST_INSERTED;
               p.refs = 16'd1;
            end
         end
      end else if (idx < 0) begin
         p.status = ST_UNCACHED;
      end else if (sh_refs[idx] == 0) begin
         p.status = ST_REL_ERROR;
      end else begin
         sh_refs[idx]--;
         sh_dirty[idx] = sh_dirty[idx] | r.dirty;
         if (sh_refs[idx] == 0) begin
            free_push(idx);
            p.status = ST_FREED;
         end else begin
            p.status = ST_HELD;
         end
         p.refs = 16'(sh_refs[idx]);
      end
      return p;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         wait_cnt <= 0;
      end else if (start) begin
         if (!busy) begin
            expected_rsps.push_back(cache_predict(pending_reqs.pop_front()));
            start <= 1'b0;
         end
      end else if (pending_reqs.size() > 0) begin
         if (pending_reqs[0].drain && expected_rsps.size() > 0) begin
            wait_cnt <= 0;
         end else if (wait_cnt < pending_reqs[0].gap) begin
            wait_cnt <= wait_cnt + 1;
         end else begin
            wait_cnt <= 0;
            req_mode <= pending_reqs[0].mode;
            req_node_id <= pending_reqs[0].node_id;
            req_dirty <= pending_reqs[0].dirty;
            start <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      cache_rsp_type exp_rsp;
      if (!reset && done) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result, status %0d", rsp_status);
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_status !== exp_rsp.status || rsp_evicted_valid !== exp_rsp.ev_valid ||
                rsp_evicted_id !== exp_rsp.ev_id || rsp_evicted_dirty !== exp_rsp.ev_dirty ||
                rsp_ref_count !== exp_rsp.refs) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp st %0d ev %0b id %h d %0b rc %0d",
                            " / got st %0d ev %0b id %h d %0b rc %0d"},
                           exp_rsp.status, exp_rsp.ev_valid, exp_rsp.ev_id, exp_rsp.ev_dirty,
                           exp_rsp.refs, rsp_status, rsp_evicted_valid, rsp_evicted_id,
                           rsp_evicted_dirty, rsp_ref_count);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL refcounted_node_cache");
         $finish;
      end
   end

   task automatic queue_req(logic mode, node_id_type id, logic dirty, int gap = -1,
                            bit drain = 0);
      cache_req_type r;
      r.mode = mode;
      r.node_id = id;
      r.dirty = dirty;
      r.gap = (gap < 0) ? (($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, MAX_GAP)))
                        : gap;
      r.drain = drain;
      pending_reqs.push_back(r);
   endtask

   initial begin
      node_id_type key_pool [72];
      node_id_type id;
      int retrieve_pct;
      for (int i = 0; i < 72; i++) key_pool[i] = $urandom();
      key_pool[0] = 32'h0;
      key_pool[1] = 32'hFFFF_FFFF;

      // directed: extremes, hit with dirty ignored, uncached, held, freed, release error
      queue_req(MODE_RETRIEVE, 32'h0, 1'b0);
      queue_req(MODE_RETRIEVE, 32'hFFFF_FFFF, 1'b1);
      queue_req(MODE_RETRIEVE, 32'h0, 1'b1);
      queue_req(MODE_RELEASE, 32'h1234_5678, 1'b1);
      queue_req(MODE_RELEASE, 32'h0, 1'b1);
      queue_req(MODE_RELEASE, 32'h0, 1'b0);
      queue_req(MODE_RELEASE, 32'h0, 1'b0);
      queue_req(MODE_RELEASE, 32'hFFFF_FFFF, 1'b0);
      queue_req(MODE_RETRIEVE, 32'h0, 1'b0);
      queue_req(MODE_RELEASE, 32'h0, 1'b1);

      // fill with held entries, evicting the free ones, then a miss with nothing evictable
      for (int i = 0; i < NUM_ENTRIES; i++) queue_req(MODE_RETRIEVE, 32'h8000_0000 + i, i[0]);
      queue_req(MODE_RETRIEVE, 32'h7FFF_FFFF, 1'b1);
      for (int i = 0; i < NUM_ENTRIES; i++) queue_req(MODE_RELEASE, 32'h8000_0000 + i, i[1]);
      queue_req(MODE_RETRIEVE, 32'h8000_0005, 1'b0, 0, 1);

      // random phases alternating retrieve-heavy and release-heavy
      for (int i = 0; i < 1710; i++) begin
         if (i % 200 == 0) retrieve_pct = (i / 200) % 2 ? 35 : 70;
         id = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 71)] : $urandom();
         queue_req(($urandom_range(0, 99) < retrieve_pct) ? MODE_RETRIEVE : MODE_RELEASE,
                   id, 1'($urandom_range(0, 1)), -1, (i % 500 == 250));
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (pending_reqs.size() == 0 && !start && expected_rsps.size() == 0);
      repeat (30) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("PASS refcounted_node_cache");
      else
         $display("FAIL refcounted_node_cache");
      $finish;
   end
endmodule
